// ===== src/mbhr_pkg.sv =====
// ----------------------------------------------------------------------------
// mbhr_pkg
// Types and constants of the holding register slave: sequencer states,
// response kinds, function and exception codes.
// ----------------------------------------------------------------------------
package mbhr_pkg;

  typedef enum logic [5:0] {
    ST_RX    = 6'b000001,
    ST_CHECK = 6'b000010,
    ST_WRA   = 6'b000100,
    ST_WRB   = 6'b001000,
    ST_WRC   = 6'b010000,
    ST_EMIT  = 6'b100000
  } state_t;

  typedef enum logic [1:0] {
    RSP_EXC  = 2'd0,
    RSP_READ = 2'd1,
    RSP_ECHO = 2'd2
  } rsp_t;

  localparam logic [7:0] FC_READ_COILS  = 8'h01;
  localparam logic [7:0] FC_READ_DISC   = 8'h02;
  localparam logic [7:0] FC_READ_HOLD   = 8'h03;
  localparam logic [7:0] FC_READ_INPUT  = 8'h04;
  localparam logic [7:0] FC_WRITE_COIL  = 8'h05;
  localparam logic [7:0] FC_WRITE_REG   = 8'h06;
  localparam logic [7:0] FC_WRITE_COILS = 8'h0F;
  localparam logic [7:0] FC_WRITE_REGS  = 8'h10;

  localparam logic [7:0] EXC_FLAG          = 8'h80;
  localparam logic [7:0] EXC_ILLEGAL_FUNC  = 8'h01;
  localparam logic [7:0] EXC_ILLEGAL_ADDR  = 8'h02;
  localparam logic [7:0] EXC_ILLEGAL_VALUE = 8'h03;

  localparam logic [15:0] REG_BASE = 16'h0100;

  // Frame layout
  localparam int HDR_BYTES     = 6;  // address, function, two words
  localparam int WM_DATA_OFS   = 7;  // first data byte of a multiple write
  localparam int MIN_FIXED_LEN = 8;  // shortest read or single write, CRC included
  localparam int MIN_WM_LEN    = 9;  // multiple write without data

endpackage

// ===== src/modbus_holding_register_slave_top.sv =====
// ----------------------------------------------------------------------------
// modbus_holding_register_slave_top
// Modbus RTU slave over a file of holding registers (read, single write,
// multiple write), fed one request byte per item, answering without CRC.
// ----------------------------------------------------------------------------
// Usage:
// - in_*: one received frame byte per item, CRC bytes included. in_tlast marks
//   the last byte; in_tuser carries the receiver's CRC verdict with it.
// - out_*: response bytes, one per item, out_tlast on the final byte. The
//   transmitter appends the CRC. Dropped frames produce no item at all.
// - cfg_*: writes the station address; always ready, write it while idle.
// Timing:
// - Bytes that are not the last are taken one per cycle; in_tready stays high.
// - After the last byte, a decode state, then the response bytes leave one
//   per cycle from the output register while the receiver takes them. A
//   multiple write first spends three steps per register on the frame buffer
//   port (read high byte, read low byte, store).
// - in_tready is low from the last byte until the final response byte has
//   been loaded; that byte may still wait in the output register while the
//   next frame starts.
// - A stalled receiver holds the output register and the emit sequencer.
// Reset: synchronous, active low. Clears the holding registers, frame flags
// and the output valid flag; the station address returns to 1.
// ----------------------------------------------------------------------------
module modbus_holding_register_slave_top
  import mbhr_pkg::*;
#(
  parameter int HOLDING_REGS = 30,
  parameter int FRAME_BYTES  = 128
) (
  input  logic       clk,
  input  logic       rst_n,
  // request bytes
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] rx_byte
  input  logic       in_tlast,   // frame_end
  input  logic       in_tuser,   // [0] crc_ok
  // response bytes
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] tx_byte
  output logic       out_tlast,  // last
  // station address
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_data    // [7:0] slave_address
);

  localparam int AW = $clog2(FRAME_BYTES);
  localparam int IW = (HOLDING_REGS > 1) ? $clog2(HOLDING_REGS) : 1;
  localparam int CW = IW + 1;
  localparam int LW = $clog2(2 * HOLDING_REGS + 3);

  state_t state_r, state_nxt;

  logic [7:0]    slave_addr_r;
  logic [7:0]    byte_cnt_r, byte_cnt_nxt;
  logic          mismatch_r, mismatch_nxt;
  logic          ovf_r, ovf_nxt;
  logic          crc_ok_r, crc_ok_nxt;
  logic [7:0]    hdr_r [HDR_BYTES];
  rsp_t          rsp_r, rsp_nxt;
  logic [7:0]    code_r, code_nxt;
  logic [7:0]    err_r, err_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [IW-1:0] wp_r, wp_nxt;
  logic [AW-1:0] rp_r, rp_nxt;
  logic [7:0]    hi_r, hi_nxt;
  logic [LW-1:0] k_r, k_nxt;
  logic [LW-1:0] last_idx_r, last_idx_nxt;
  logic          lo_r, lo_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [7:0]    out_data_r, out_data_nxt;
  logic          out_last_r, out_last_nxt;

  logic [7:0]    fbuf [FRAME_BYTES];
  logic [7:0]    rd_data_r;
  logic [AW-1:0] rd_addr;
  logic          mem_we;

  logic          in_acc;
  logic          store_ok;
  logic          hdr_we;
  logic [7:0]    hv [HDR_BYTES];
  logic [7:0]    fc;
  logic [15:0]   start;
  logic [15:0]   count;
  logic [16:0]   span;
  logic [17:0]   wm_need;
  logic          range_bad;
  logic          idx_bad;
  logic          short_fixed;
  logic          short_wm;
  logic          known_fc;
  logic          drop;

  logic          st_we;
  logic [IW-1:0] st_waddr;
  logic [15:0]   st_wdata;
  logic [15:0]   st_rdata;
  logic          emit_go;
  logic [7:0]    emit_byte;

  assign cfg_ready  = 1'b1;
  assign in_tready  = (state_r == ST_RX);
  assign in_acc     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  // Store a byte while it fits and nothing of this frame has been lost yet
  assign store_ok = ({1'b0, byte_cnt_r} < 9'(FRAME_BYTES)) && !ovf_r;
  assign mem_we   = in_acc && store_ok;
  assign hdr_we   = in_acc && (byte_cnt_r < 8'(HDR_BYTES));

  // Header bytes beyond the received length read as zero
  always_comb begin
    for (int i = 0; i < HDR_BYTES; i++) begin
      hv[i] = (byte_cnt_r > 8'(i)) ? hdr_r[i] : 8'h00;
    end
  end

  // Decode terms, valid in the check cycle
  assign fc          = hv[1];
  assign start       = {hv[2], hv[3]} - REG_BASE;
  assign count       = {hv[4], hv[5]};
  assign span        = {1'b0, start} + {1'b0, count};
  assign range_bad   = span > 17'(HOLDING_REGS);
  assign idx_bad     = start >= 16'(HOLDING_REGS);
  assign short_fixed = byte_cnt_r < 8'(MIN_FIXED_LEN);
  assign wm_need     = 18'(MIN_WM_LEN) + {1'b0, count, 1'b0};
  assign short_wm    = {10'b0, byte_cnt_r} < wm_need;
  assign known_fc    = (fc == FC_READ_COILS) || (fc == FC_READ_DISC) ||
                       (fc == FC_READ_HOLD) || (fc == FC_READ_INPUT) ||
                       (fc == FC_WRITE_COIL) || (fc == FC_WRITE_REG) ||
                       (fc == FC_WRITE_COILS) || (fc == FC_WRITE_REGS);
  assign drop        = mismatch_r || ovf_r || (byte_cnt_r < 8'd2) ||
                       !known_fc || !crc_ok_r;

  // Response byte at position k_r
  always_comb begin
    emit_byte = 8'h00;
    case (k_r)
      LW'(0): emit_byte = slave_addr_r;
      LW'(1): emit_byte = code_r;
      LW'(2): emit_byte = (rsp_r == RSP_ECHO) ? hdr_r[2] : err_r;
      default: begin
        if (rsp_r == RSP_READ) begin
          emit_byte = lo_r ? st_rdata[7:0] : st_rdata[15:8];
        end else if (k_r == LW'(3)) begin
          emit_byte = hdr_r[3];
        end else if (k_r == LW'(4)) begin
          emit_byte = hdr_r[4];
        end else begin
          emit_byte = hdr_r[5];
        end
      end
    endcase
  end

  assign emit_go = (state_r == ST_EMIT) && (!out_valid_r || out_tready);

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    byte_cnt_nxt  = byte_cnt_r;
    mismatch_nxt  = mismatch_r;
    ovf_nxt       = ovf_r;
    crc_ok_nxt    = crc_ok_r;
    rsp_nxt       = rsp_r;
    code_nxt      = code_r;
    err_nxt       = err_r;
    cnt_nxt       = cnt_r;
    wp_nxt        = wp_r;
    rp_nxt        = rp_r;
    hi_nxt        = hi_r;
    k_nxt         = k_r;
    last_idx_nxt  = last_idx_r;
    lo_nxt        = lo_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    out_last_nxt  = out_last_r;
    rd_addr       = rp_r;
    st_we         = 1'b0;
    st_waddr      = wp_r;
    st_wdata      = {hi_r, rd_data_r};

    case (state_r)
      ST_RX: begin
        if (in_acc) begin
          if (byte_cnt_r == 8'd0) begin
            mismatch_nxt = (in_tdata != slave_addr_r);
          end
          if (!store_ok) begin
            ovf_nxt = 1'b1;
          end
          if (byte_cnt_r != 8'hFF) begin
            byte_cnt_nxt = byte_cnt_r + 8'd1;
          end else begin
            ovf_nxt = 1'b1;
          end
          if (in_tlast) begin
            crc_ok_nxt = in_tuser;
            state_nxt  = ST_CHECK;
          end
        end
      end

      ST_CHECK: begin
        // End of frame: clear the frame flags whatever the verdict
        byte_cnt_nxt = '0;
        mismatch_nxt = 1'b0;
        ovf_nxt      = 1'b0;
        k_nxt        = '0;
        lo_nxt       = 1'b0;
        code_nxt     = fc | EXC_FLAG;
        rsp_nxt      = RSP_EXC;
        last_idx_nxt = LW'(2);
        wp_nxt       = start[IW-1:0];
        cnt_nxt      = count[CW-1:0];
        rp_nxt       = AW'(WM_DATA_OFS);
        state_nxt    = ST_EMIT;
        if (drop) begin
          state_nxt = ST_RX;
        end else if (fc == FC_READ_HOLD) begin
          if (range_bad) begin
            err_nxt = EXC_ILLEGAL_ADDR;
          end else if (short_fixed) begin
            err_nxt = EXC_ILLEGAL_VALUE;
          end else begin
            rsp_nxt      = RSP_READ;
            code_nxt     = fc;
            err_nxt      = {count[6:0], 1'b0};
            last_idx_nxt = LW'(2) + {count[LW-2:0], 1'b0};
          end
        end else if (fc == FC_WRITE_REG) begin
          if (idx_bad) begin
            err_nxt = EXC_ILLEGAL_ADDR;
          end else if (short_fixed) begin
            err_nxt = EXC_ILLEGAL_VALUE;
          end else begin
            st_we        = 1'b1;
            st_waddr     = start[IW-1:0];
            st_wdata     = count;
            rsp_nxt      = RSP_ECHO;
            code_nxt     = fc;
            last_idx_nxt = LW'(5);
          end
        end else if (fc == FC_WRITE_REGS) begin
          if (range_bad) begin
            err_nxt = EXC_ILLEGAL_ADDR;
          end else if (short_wm) begin
            err_nxt = EXC_ILLEGAL_VALUE;
          end else begin
            rsp_nxt      = RSP_ECHO;
            code_nxt     = fc;
            last_idx_nxt = LW'(5);
            if (count != 16'd0) begin
              state_nxt = ST_WRA;
            end
          end
        end else begin
          err_nxt = EXC_ILLEGAL_FUNC;
        end
      end

      // Multiple write: fetch high byte, fetch low byte, store the word
      ST_WRA: begin
        state_nxt = ST_WRB;
      end

      ST_WRB: begin
        hi_nxt    = rd_data_r;
        rd_addr   = rp_r + AW'(1);
        state_nxt = ST_WRC;
      end

      ST_WRC: begin
        st_we   = 1'b1;
        wp_nxt  = wp_r + IW'(1);
        rp_nxt  = rp_r + AW'(2);
        cnt_nxt = cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          state_nxt = ST_EMIT;
        end else begin
          state_nxt = ST_WRA;
        end
      end

      ST_EMIT: begin
        if (emit_go) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = emit_byte;
          out_last_nxt  = (k_r == last_idx_r);
          k_nxt         = k_r + LW'(1);
          // Advance to the next register after its low byte
          if ((rsp_r == RSP_READ) && (k_r >= LW'(3))) begin
            lo_nxt = !lo_r;
            if (lo_r) begin
              wp_nxt = wp_r + IW'(1);
            end
          end
          if (k_r == last_idx_r) begin
            state_nxt = ST_RX;
          end
        end
      end

      default: begin
        state_nxt = ST_RX;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_RX;
      slave_addr_r <= 8'd1;
      byte_cnt_r   <= '0;
      mismatch_r   <= 1'b0;
      ovf_r        <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      byte_cnt_r  <= byte_cnt_nxt;
      mismatch_r  <= mismatch_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        slave_addr_r <= cfg_data;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    crc_ok_r   <= crc_ok_nxt;
    rsp_r      <= rsp_nxt;
    code_r     <= code_nxt;
    err_r      <= err_nxt;
    cnt_r      <= cnt_nxt;
    wp_r       <= wp_nxt;
    rp_r       <= rp_nxt;
    hi_r       <= hi_nxt;
    k_r        <= k_nxt;
    last_idx_r <= last_idx_nxt;
    lo_r       <= lo_nxt;
    out_data_r <= out_data_nxt;
    out_last_r <= out_last_nxt;
    if (state_r == ST_CHECK) begin
      // Hold the zero-masked header for the echo
      for (int i = 0; i < HDR_BYTES; i++) begin
        hdr_r[i] <= hv[i];
      end
    end else if (hdr_we) begin
      hdr_r[byte_cnt_r[2:0]] <= in_tdata;
    end
  end

  // Frame buffer
  always_ff @(posedge clk) begin
    if (mem_we) begin
      fbuf[byte_cnt_r[AW-1:0]] <= in_tdata;
    end
    rd_data_r <= fbuf[rd_addr];
  end

  mbhr_store #(
    .DEPTH (HOLDING_REGS),
    .IW    (IW)
  ) u_store (
    .clk   (clk),
    .rst_n (rst_n),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (st_wdata),
    .raddr (wp_r),
    .rdata (st_rdata)
  );

endmodule

// ===== src/mbhr_store.sv =====
// ----------------------------------------------------------------------------
// mbhr_store
// Holding register file: one write and one read port, cleared by reset.
// ----------------------------------------------------------------------------
module mbhr_store #(
  parameter int DEPTH = 30,
  parameter int IW    = 5
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          we,
  input  logic [IW-1:0] waddr,
  input  logic [15:0]   wdata,
  input  logic [IW-1:0] raddr,
  output logic [15:0]   rdata
);

  logic [15:0] regs_r [DEPTH];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DEPTH; i++) begin
        regs_r[i] <= '0;
      end
    end else if (we && (int'(waddr) < DEPTH)) begin
      regs_r[waddr] <= wdata;
    end
  end

  assign rdata = (int'(raddr) < DEPTH) ? regs_r[raddr] : '0;

endmodule

// ===== src/mbhr_checker.sv =====
// ----------------------------------------------------------------------------
// mbhr_checker
// Port-level checks of the holding register slave, bound to the top level.
// ----------------------------------------------------------------------------
module mbhr_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_tvalid,
  input logic       in_tready,
  input logic       in_tlast,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic       out_tlast
);

  // Reset leaves the block idle and able to take a byte
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && in_tready)
    else $error("block not idle after reset");

  // The last byte of a frame closes the input until the reply is loaded
  a_close_after_end: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tlast |=> !in_tready)
    else $error("input still open after frame end");

  // A response leaves without gaps until its last byte
  a_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && !out_tlast |=> out_tvalid)
    else $error("gap inside a response");

  // No new frame starts while a response is still in progress
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> !in_tready)
    else $error("input open during a response");

  // A stalled response byte holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("stalled response byte changed");

endmodule

bind modbus_holding_register_slave_top mbhr_checker u_mbhr_checker (.*);
